/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are off while arst_n is low.

// Implication in the same cycle.
`define SVAG_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define SVAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/svag_pkg.sv */
`default_nettype none

package svag_pkg;

	localparam int PACK_DIMS = 4;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = 32;
	localparam int OFF_W     = 36;
	localparam int DIV_W     = 48;
	localparam int PROD_W    = 50;
	localparam int DCNT_W    = 5;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [2:0]  DIM_COUNT_RST     = 3'd1;
	localparam logic [31:0] SOURCE_LENGTH_RST = 32'd1;

	typedef enum logic [2:0] {
		REG_DIM_COUNT     = 3'd0,
		REG_DIM_SIZES     = 3'd1,
		REG_DIM_STRIDES   = 3'd2,
		REG_BASE_OFFSET   = 3'd3,
		REG_SOURCE_LENGTH = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] flat_index;
	} req_t;

	typedef struct packed {
		logic [31:0] source_index;
		logic        out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [2:0]         dim_count;
		logic [63:0]        dim_sizes;
		logic [63:0]        dim_strides;
		logic signed [31:0] base_offset;
		logic [31:0]        source_length;
	} cfg_t;

	typedef logic [3:0] upc_t;

	localparam upc_t UA_IDLE     = 4'd0;
	localparam upc_t UA_ST_INIT  = 4'd1;
	localparam upc_t UA_ST_PREP  = 4'd2;
	localparam upc_t UA_ST_PREPW = 4'd3;
	localparam upc_t UA_ST_DIV0  = 4'd4;
	localparam upc_t UA_ST_DIV   = 4'd5;
	localparam upc_t UA_ST_DIGIT = 4'd6;
	localparam upc_t UA_ST_ACC   = 4'd7;
	localparam upc_t UA_DONE     = 4'd8;
	localparam upc_t UA_AD_INC   = 4'd9;
	localparam upc_t UA_AD_TEST  = 4'd10;
	localparam upc_t UA_AD_CARRY = 4'd11;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DIV_SIZE,
		MUL_Q_STRIDE,
		MUL_SIZE_STRIDE
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD_BASE,
		ACC_ADD_PROD,
		ACC_SUB_PROD,
		ACC_ADD_STRIDE
	} acc_op_t;

	typedef enum logic [2:0] {
		DIG_NONE,
		DIG_CLEAR_ALL,
		DIG_WRITE_Q,
		DIG_INC,
		DIG_ZERO
	} dig_op_t;

	typedef enum logic [1:0] {
		PTR_NONE,
		PTR_LAST,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_INIT,
		DIV_STEP
	} div_op_t;

	typedef enum logic [1:0] {
		TAB_NONE,
		TAB_INIT,
		TAB_WRITE
	} tab_op_t;

	typedef enum logic [2:0] {
		JMP_NONE,
		JMP_ALWAYS,
		JMP_DISPATCH,
		JMP_PTR_ZERO,
		JMP_PTR_NOT_LAST,
		JMP_DIV_MORE,
		JMP_NO_CARRY
	} jmp_t;

	typedef struct packed {
		mul_sel_t mul;
		acc_op_t  acc;
		dig_op_t  dig;
		ptr_op_t  ptr;
		div_op_t  div;
		tab_op_t  tab;
		logic     rem_load;
		logic     emit;
		jmp_t     jmp;
		upc_t     target;
	} uword_t;

	typedef struct packed {
		logic ptr_zero;
		logic ptr_last;
		logic div_more;
		logic carry;
		logic out_free;
	} stat_t;

	localparam uword_t UWORD_NOP = '{
		mul:      MUL_NONE,
		acc:      ACC_NONE,
		dig:      DIG_NONE,
		ptr:      PTR_NONE,
		div:      DIV_NONE,
		tab:      TAB_NONE,
		rem_load: 1'b0,
		emit:     1'b0,
		jmp:      JMP_NONE,
		target:   UA_IDLE
	};

	// Control store. Without a taken jump the program steps to the next word.
	function automatic uword_t urom(input upc_t a);
		uword_t w;
		w = UWORD_NOP;
		case (a)
			UA_IDLE: begin
				w.ptr = PTR_LAST;
				w.jmp = JMP_DISPATCH;
			end
			UA_ST_INIT: begin
				w.acc = ACC_LOAD_BASE;
				w.dig = DIG_CLEAR_ALL;
				w.tab = TAB_INIT;
			end
			// row-major divisors, innermost outward
			UA_ST_PREP: begin
				w.mul    = MUL_DIV_SIZE;
				w.jmp    = JMP_PTR_ZERO;
				w.target = UA_ST_DIV0;
			end
			UA_ST_PREPW: begin
				w.tab    = TAB_WRITE;
				w.ptr    = PTR_DEC;
				w.jmp    = JMP_ALWAYS;
				w.target = UA_ST_PREP;
			end
			UA_ST_DIV0: begin
				w.div = DIV_INIT;
			end
			UA_ST_DIV: begin
				w.div    = DIV_STEP;
				w.jmp    = JMP_DIV_MORE;
				w.target = UA_ST_DIV;
			end
			UA_ST_DIGIT: begin
				w.dig      = DIG_WRITE_Q;
				w.rem_load = 1'b1;
				w.mul      = MUL_Q_STRIDE;
			end
			UA_ST_ACC: begin
				w.acc    = ACC_ADD_PROD;
				w.ptr    = PTR_INC;
				w.jmp    = JMP_PTR_NOT_LAST;
				w.target = UA_ST_DIV0;
			end
			UA_DONE: begin
				w.emit   = 1'b1;
				w.jmp    = JMP_ALWAYS;
				w.target = UA_IDLE;
			end
			UA_AD_INC: begin
				w.dig = DIG_INC;
				w.acc = ACC_ADD_STRIDE;
			end
			UA_AD_TEST: begin
				w.mul    = MUL_SIZE_STRIDE;
				w.jmp    = JMP_NO_CARRY;
				w.target = UA_DONE;
			end
			UA_AD_CARRY: begin
				w.acc    = ACC_SUB_PROD;
				w.dig    = DIG_ZERO;
				w.ptr    = PTR_DEC;
				w.jmp    = JMP_ALWAYS;
				w.target = UA_AD_INC;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = UA_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/strided_view_address_generator.sv */
// Channel   Direction  Word                          Handshake
// req       in         cmd, flat_index               req_valid / req_stall
// rsp       out        source_index, out_of_range    rsp_valid / rsp_stall
// apb       in/out     five registers at 8*i         psel, penable, pwrite, pready
//
// Advance: bump the innermost digit, add its stride, and per carried dimension zero it,
// take back size*stride and move out. Start: the one-bit-per-cycle divider (32 steps
// per digit) and the shared 33x17 multiplier serve each dimension; idle between words.
// Reset clears digits, offset and sequencer; no memory sweep is needed.
// req_stall is high while a program runs; a result waiting in the output
// register does not block the next word, only the final result step.

`default_nettype none

`include "assert_macros.svh"

module strided_view_address_generator #(
	parameter int MAX_DIMS = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [svag_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [svag_pkg::PDATA_W-1:0]   pwdata,
	output logic      [svag_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire svag_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output svag_pkg::rsp_t                      rsp
);

	svag_pkg::cfg_t   cfg;
	svag_pkg::uword_t ctrl;
	svag_pkg::stat_t  stat;
	logic             idle;
	logic             accept;

	assign req_stall = !idle;
	assign accept    = req_valid && !req_stall;

	svag_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	svag_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (req.cmd),
		.stat   (stat),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	svag_datapath #(
		.MAX_DIMS (MAX_DIMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctrl       (ctrl),
		.accept     (accept),
		.flat_index (req.flat_index),
		.rsp_stall  (rsp_stall),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp)
	);

	`SVAG_ASSERT_NEXT(a_accept_starts, accept, req_stall, "accepted word did not start a program")
	`SVAG_ASSERT_NEXT(a_emit_loads, ctrl.emit && stat.out_free, rsp_valid, "result step lost its word")
	`SVAG_ASSERT_HOLDS(a_clamp_zero, rsp_valid && rsp.out_of_range, rsp.source_index == '0, "clamped index not zero")

endmodule

`default_nettype wire

/* rtl/core/svag_cfg_regs.sv */
`default_nettype none

module svag_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [svag_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [svag_pkg::PDATA_W-1:0]       pwdata,
	output logic      [svag_pkg::PDATA_W-1:0]       prdata,
	output logic                                    pready,
	output svag_pkg::cfg_t                          cfg
);

	svag_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[svag_pkg::PADDR_W-1 -: 3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_count     <= svag_pkg::DIM_COUNT_RST;
			cfg_q.dim_sizes     <= '0;
			cfg_q.dim_strides   <= '0;
			cfg_q.base_offset   <= '0;
			cfg_q.source_length <= svag_pkg::SOURCE_LENGTH_RST;
		end else if (wr_en) begin
			case (reg_sel)
				svag_pkg::REG_DIM_COUNT:     cfg_q.dim_count     <= pwdata[2:0];
				svag_pkg::REG_DIM_SIZES:     cfg_q.dim_sizes     <= pwdata;
				svag_pkg::REG_DIM_STRIDES:   cfg_q.dim_strides   <= pwdata;
				svag_pkg::REG_BASE_OFFSET:   cfg_q.base_offset   <= pwdata[31:0];
				svag_pkg::REG_SOURCE_LENGTH: cfg_q.source_length <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			svag_pkg::REG_DIM_COUNT:     prdata = 64'(cfg_q.dim_count);
			svag_pkg::REG_DIM_SIZES:     prdata = cfg_q.dim_sizes;
			svag_pkg::REG_DIM_STRIDES:   prdata = cfg_q.dim_strides;
			svag_pkg::REG_BASE_OFFSET:   prdata = {32'd0, cfg_q.base_offset};
			svag_pkg::REG_SOURCE_LENGTH: prdata = 64'(cfg_q.source_length);
			default:                     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/svag_useq.sv */
`default_nettype none

module svag_useq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             cmd,
	input  wire svag_pkg::stat_t  stat,
	output svag_pkg::uword_t      ctrl,
	output logic                  idle
);

	svag_pkg::upc_t upc_q;
	svag_pkg::upc_t upc_nxt;
	svag_pkg::upc_t target;
	logic           taken;
	logic           hold;

	always_comb begin
		ctrl   = svag_pkg::urom(upc_q);
		target = ctrl.target;
		taken  = 1'b0;
		hold   = 1'b0;
		case (ctrl.jmp)
			svag_pkg::JMP_NONE:         taken = 1'b0;
			svag_pkg::JMP_ALWAYS:       taken = 1'b1;
			svag_pkg::JMP_DISPATCH: begin
				taken  = 1'b1;
				hold   = !accept;
				target = (cmd == svag_pkg::CMD_ADVANCE) ? svag_pkg::UA_AD_INC
									: svag_pkg::UA_ST_INIT;
			end
			svag_pkg::JMP_PTR_ZERO:     taken = stat.ptr_zero;
			svag_pkg::JMP_PTR_NOT_LAST: taken = !stat.ptr_last;
			svag_pkg::JMP_DIV_MORE:     taken = stat.div_more;
			svag_pkg::JMP_NO_CARRY:     taken = !stat.carry;
			default:                    taken = 1'b0;
		endcase
		// result step waits for room in the output register
		if (ctrl.emit && !stat.out_free) begin
			hold = 1'b1;
		end
		if (hold) begin
			upc_nxt = upc_q;
		end else if (taken) begin
			upc_nxt = target;
		end else begin
			upc_nxt = upc_q + 4'd1;
		end
	end

	assign idle = (upc_q == svag_pkg::UA_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= svag_pkg::UA_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/svag_datapath.sv */
`default_nettype none

module svag_datapath #(
	parameter int MAX_DIMS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire svag_pkg::cfg_t                cfg,
	input  wire svag_pkg::uword_t              ctrl,
	input  wire logic                          accept,
	input  wire logic [svag_pkg::IDX_W-1:0]    flat_index,
	input  wire logic                          rsp_stall,
	output svag_pkg::stat_t                    stat,
	output logic                               rsp_valid,
	output svag_pkg::rsp_t                     rsp
);

	localparam int NDIM = (MAX_DIMS < svag_pkg::PACK_DIMS) ? MAX_DIMS : svag_pkg::PACK_DIMS;
	localparam int DW   = (NDIM > 1) ? $clog2(NDIM) : 1;
	localparam logic [3:0] NDIM_N = 4'(NDIM);

	logic [DW-1:0]                  d_q;
	logic [DW-1:0]                  n_last;
	logic [3:0]                     n_act;
	logic [1:0]                     d_pack;
	logic [svag_pkg::SIZE_W-1:0]    digit_q [NDIM];
	logic [svag_pkg::DIV_W-1:0]     divtab_q [NDIM];
	logic [svag_pkg::OFF_W-1:0]     off_q;
	logic [svag_pkg::IDX_W-1:0]     rem_q;
	logic [svag_pkg::IDX_W-1:0]     r_q;
	logic [svag_pkg::IDX_W-1:0]     quo_q;
	logic [svag_pkg::DCNT_W-1:0]    div_cnt_q;
	logic signed [svag_pkg::PROD_W-1:0] prod_q;
	logic signed [32:0]             mul_a;
	logic signed [16:0]             mul_b;
	logic [svag_pkg::SIZE_W-1:0]    sz;
	logic [svag_pkg::SIZE_W-1:0]    st;
	logic [svag_pkg::SIZE_W-1:0]    dig_cur;
	logic [svag_pkg::DIV_W-1:0]     div_cur;
	logic                           div_zero;
	logic [svag_pkg::SIZE_W-1:0]    qsat;
	logic [32:0]                    r_sh;
	logic [32:0]                    r_sub;
	logic                           r_ge;
	logic                           out_free;
	logic                           bad;
	logic                           rsp_valid_q;
	svag_pkg::rsp_t                 rsp_q;

	// dimension count 0 acts as 1, larger counts saturate
	always_comb begin
		if (cfg.dim_count == 3'd0) begin
			n_act = 4'd1;
		end else if ({1'b0, cfg.dim_count} > NDIM_N) begin
			n_act = NDIM_N;
		end else begin
			n_act = {1'b0, cfg.dim_count};
		end
		n_last = DW'(n_act - 4'd1);
	end

	assign d_pack   = 2'(d_q);
	assign sz       = cfg.dim_sizes[{d_pack, 4'b0} +: svag_pkg::SIZE_W];
	assign st       = cfg.dim_strides[{d_pack, 4'b0} +: svag_pkg::SIZE_W];
	assign dig_cur  = digit_q[d_q];
	assign div_cur  = divtab_q[d_q];
	assign div_zero = (div_cur == '0);

	// zero divisor leaves a zero digit; large quotients saturate
	always_comb begin
		if (div_zero) begin
			qsat = '0;
		end else if (|quo_q[31:16]) begin
			qsat = '1;
		end else begin
			qsat = quo_q[15:0];
		end
	end

	// restoring divider, one quotient bit per step
	assign r_sh  = {r_q, quo_q[31]};
	assign r_ge  = ({15'd0, r_sh} >= div_cur);
	assign r_sub = r_sh - div_cur[32:0];

	always_comb begin
		case (ctrl.mul)
			svag_pkg::MUL_DIV_SIZE: begin
				mul_a = {1'b0, div_cur[31:0]};
				mul_b = {1'b0, sz};
			end
			svag_pkg::MUL_Q_STRIDE: begin
				mul_a = {17'd0, qsat};
				mul_b = {st[15], st};
			end
			svag_pkg::MUL_SIZE_STRIDE: begin
				mul_a = {17'd0, sz};
				mul_b = {st[15], st};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign bad      = off_q[svag_pkg::OFF_W-1] || (off_q >= {4'd0, cfg.source_length});

	assign stat.ptr_zero = (d_q == '0);
	assign stat.ptr_last = (d_q == n_last);
	assign stat.div_more = (div_cnt_q != '0);
	assign stat.carry    = (d_q != '0) && (dig_cur >= sz);
	assign stat.out_free = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q         <= '0;
			div_cnt_q   <= '0;
			off_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NDIM; i++) begin
				digit_q[i] <= '0;
			end
		end else begin
			case (ctrl.ptr)
				svag_pkg::PTR_LAST: d_q <= n_last;
				svag_pkg::PTR_INC: begin
					if (d_q != n_last) begin
						d_q <= d_q + 1'b1;
					end
				end
				svag_pkg::PTR_DEC:  d_q <= d_q - 1'b1;
				default: ;
			endcase

			case (ctrl.div)
				svag_pkg::DIV_INIT: div_cnt_q <= '1;
				svag_pkg::DIV_STEP: div_cnt_q <= div_cnt_q - 1'b1;
				default: ;
			endcase

			case (ctrl.acc)
				svag_pkg::ACC_LOAD_BASE:
					off_q <= {{4{cfg.base_offset[31]}}, cfg.base_offset};
				svag_pkg::ACC_ADD_PROD:
					off_q <= off_q + prod_q[svag_pkg::OFF_W-1:0];
				svag_pkg::ACC_SUB_PROD:
					off_q <= off_q - prod_q[svag_pkg::OFF_W-1:0];
				svag_pkg::ACC_ADD_STRIDE:
					off_q <= off_q + {{20{st[15]}}, st};
				default: ;
			endcase

			case (ctrl.dig)
				svag_pkg::DIG_CLEAR_ALL: begin
					for (int i = 0; i < NDIM; i++) begin
						digit_q[i] <= '0;
					end
				end
				svag_pkg::DIG_WRITE_Q: digit_q[d_q] <= qsat;
				svag_pkg::DIG_INC:     digit_q[d_q] <= dig_cur + 16'd1;
				svag_pkg::DIG_ZERO:    digit_q[d_q] <= '0;
				default: ;
			endcase

			if (ctrl.emit && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= flat_index;
		end else if (ctrl.rem_load && !div_zero) begin
			rem_q <= r_q;
		end

		case (ctrl.div)
			svag_pkg::DIV_INIT: begin
				r_q   <= '0;
				quo_q <= rem_q;
			end
			svag_pkg::DIV_STEP: begin
				r_q   <= r_ge ? r_sub[31:0] : r_sh[31:0];
				quo_q <= {quo_q[30:0], r_ge};
			end
			default: ;
		endcase

		if (ctrl.mul != svag_pkg::MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end

		case (ctrl.tab)
			svag_pkg::TAB_INIT:  divtab_q[n_last] <= 48'd1;
			svag_pkg::TAB_WRITE: divtab_q[d_q - 1'b1] <= prod_q[svag_pkg::DIV_W-1:0];
			default: ;
		endcase

		if (ctrl.emit && out_free) begin
			rsp_q.source_index <= bad ? '0 : off_q[31:0];
			rsp_q.out_of_range <= bad;
		end
	end

endmodule

`default_nettype wire

/* bench/tb.sv */
module tb;

	localparam int LONG_HOLD = 400;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [svag_pkg::PADDR_W-1:0]  paddr;
	logic [svag_pkg::PDATA_W-1:0]  pwdata;
	logic [svag_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	logic                          req_valid;
	logic                          req_stall;
	svag_pkg::req_t                req;
	logic                          rsp_valid;
	logic                          rsp_stall;
	svag_pkg::rsp_t                rsp;

	strided_view_address_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// view registers as last written, and the generator's own position
	svag_pkg::cfg_t view_cfg;
	logic [15:0]    digit_q [svag_pkg::PACK_DIMS];
	logic [35:0]    run_off;

	svag_pkg::rsp_t pending_indices [$];

	bit stall_on  = 1'b1;
	bit gap_on    = 1'b1;
	bit long_hold = 1'b0;

	int n_errors   = 0;
	int n_starts   = 0;
	int n_advances = 0;
	int n_clamped  = 0;
	int n_writes   = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int dims_in_use();
		int n;
		n = view_cfg.dim_count;
		if (n == 0)
			n = 1;
		if (n > svag_pkg::PACK_DIMS)
			n = svag_pkg::PACK_DIMS;
		return n;
	endfunction

	function automatic logic [63:0] view_size(int d);
		return {48'b0, view_cfg.dim_sizes[16*d +: 16]};
	endfunction

	function automatic logic [63:0] view_stride(int d);
		return {{48{view_cfg.dim_strides[16*d+15]}}, view_cfg.dim_strides[16*d +: 16]};
	endfunction

	function automatic void seek_flat_index(logic [31:0] flat);
		int n, d, k;
		logic [63:0] rem, div, q, acc;
		n = dims_in_use();
		rem = {32'b0, flat};
		acc = {{32{view_cfg.base_offset[31]}}, view_cfg.base_offset};
		for (d = 0; d < svag_pkg::PACK_DIMS; d++)
			digit_q[d] = '0;
		for (d = 0; d < n; d++) begin
			div = 64'd1;
			for (k = d + 1; k < n; k++)
				div = div * view_size(k);
			q = '0;
			// zero inner size: digit stays 0, remainder carries through
			if (div != 0) begin
				q = rem / div;
				rem = rem % div;
			end
			if (q > 64'hFFFF)
				q = 64'hFFFF;
			digit_q[d] = q[15:0];
			acc = acc + q * view_stride(d);
		end
		run_off = acc[35:0];
	endfunction

	function automatic void step_view();
		int d;
		logic [63:0] acc;
		d = dims_in_use() - 1;
		acc = {28'b0, run_off};
		digit_q[d] = digit_q[d] + 16'd1;
		acc = acc + view_stride(d);
		while (d > 0 && {48'b0, digit_q[d]} >= view_size(d)) begin
			acc = acc - view_size(d) * view_stride(d);
			digit_q[d] = '0;
			d--;
			digit_q[d] = digit_q[d] + 16'd1;
			acc = acc + view_stride(d);
		end
		run_off = acc[35:0];
	endfunction

	function automatic svag_pkg::rsp_t clamp_source_index();
		svag_pkg::rsp_t r;
		r.out_of_range = run_off[35] || (run_off >= {4'b0, view_cfg.source_length});
		r.source_index = r.out_of_range ? '0 : run_off[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		n_errors++;
		if (n_errors <= 40)
			$display("ERROR at %0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin : check_rsp
		svag_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_indices.size() == 0) begin
				report_mismatch("result with nothing pending", rsp.source_index, '0);
			end else begin
				want = pending_indices.pop_front();
				if (want.out_of_range)
					n_clamped++;
				if (rsp.source_index !== want.source_index)
					report_mismatch("source_index", rsp.source_index, want.source_index);
				if (rsp.out_of_range !== want.out_of_range)
					report_mismatch("out_of_range", {31'b0, rsp.out_of_range},
						{31'b0, want.out_of_range});
			end
		end
	end

	// receiver: random stall bursts, or one long hold when asked
	initial begin : rsp_side
		int hold;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_stall <= 1'b1;
				hold = LONG_HOLD;
			end else if (stall_on && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				hold = $urandom_range(1, 15);
			end else begin
				rsp_stall <= 1'b0;
				hold = $urandom_range(1, 12);
			end
			repeat (hold - 1) @(posedge clk);
		end
	end

	task automatic write_reg(svag_pkg::reg_idx_t r, logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (r)
			svag_pkg::REG_DIM_COUNT:     view_cfg.dim_count     = v[2:0];
			svag_pkg::REG_DIM_SIZES:     view_cfg.dim_sizes     = v;
			svag_pkg::REG_DIM_STRIDES:   view_cfg.dim_strides   = v;
			svag_pkg::REG_BASE_OFFSET:   view_cfg.base_offset   = v[31:0];
			svag_pkg::REG_SOURCE_LENGTH: view_cfg.source_length = v[31:0];
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	// one word per call; valid stays up unless a gap follows
	task automatic send_word(logic cmd, logic [31:0] flat);
		svag_pkg::req_t w;
		int gap;
		w.cmd = cmd;
		w.flat_index = flat;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (cmd == svag_pkg::CMD_START) begin
			seek_flat_index(flat);
			n_starts++;
		end else begin
			step_view();
			n_advances++;
		end
		pending_indices.push_back(clamp_source_index());
		if (gap_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_indices.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_advance();
		send_word(svag_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
		send_word(svag_pkg::CMD_ADVANCE, 32'h0000_0000);
		drain_results();
	endtask

	task automatic test_strided_walk();
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd3);
		write_reg(svag_pkg::REG_DIM_SIZES, 64'h0000_0004_0003_0002);
		write_reg(svag_pkg::REG_DIM_STRIDES, 64'h0000_FFFE_0008_0001);
		write_reg(svag_pkg::REG_BASE_OFFSET, 64'd40);
		write_reg(svag_pkg::REG_SOURCE_LENGTH, 64'd100);
		send_word(svag_pkg::CMD_START, 32'd0);
		repeat (4) send_word(svag_pkg::CMD_ADVANCE, $urandom);
		// last element: the next advance carries through both inner dims
		send_word(svag_pkg::CMD_START, 32'd23);
		send_word(svag_pkg::CMD_ADVANCE, 32'd0);
		send_word(svag_pkg::CMD_START, 32'hFFFF_FFFF);
		drain_results();
	endtask

	task automatic test_dim_count_limits();
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd0);
		send_word(svag_pkg::CMD_START, 32'd5);
		send_word(svag_pkg::CMD_ADVANCE, 32'd0);
		drain_results();
		// dim 3 has size 0: zero divisors on start, carries on every advance
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd7);
		send_word(svag_pkg::CMD_START, 32'h0001_0000);
		send_word(svag_pkg::CMD_ADVANCE, 32'd0);
		send_word(svag_pkg::CMD_ADVANCE, 32'd0);
		drain_results();
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd5);
		send_word(svag_pkg::CMD_START, 32'd1);
		drain_results();
	endtask

	task automatic test_clamping();
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd1);
		write_reg(svag_pkg::REG_BASE_OFFSET, 64'h0000_0000_FFFF_FFFB);
		send_word(svag_pkg::CMD_START, 32'd0);
		send_word(svag_pkg::CMD_START, 32'd7);
		drain_results();
		write_reg(svag_pkg::REG_SOURCE_LENGTH, 64'd0);
		send_word(svag_pkg::CMD_START, 32'd7);
		drain_results();
		write_reg(svag_pkg::REG_BASE_OFFSET, 64'h0000_0000_7FFF_FFFF);
		write_reg(svag_pkg::REG_SOURCE_LENGTH, 64'h0000_0000_FFFF_FFFF);
		send_word(svag_pkg::CMD_START, 32'd0);
		send_word(svag_pkg::CMD_ADVANCE, 32'd0);
		drain_results();
		write_reg(svag_pkg::REG_DIM_STRIDES, 64'h0000_0000_0000_7FFF);
		send_word(svag_pkg::CMD_START, 32'hFFFF_FFFF);
		drain_results();
	endtask

	task automatic test_output_backpressure();
		write_reg(svag_pkg::REG_DIM_COUNT, 64'd2);
		write_reg(svag_pkg::REG_DIM_SIZES, 64'h0000_0000_0005_0006);
		gap_on = 1'b0;
		long_hold = 1'b1;
		send_word(svag_pkg::CMD_START, 32'd3);
		repeat (24) send_word(svag_pkg::CMD_ADVANCE, $urandom);
		gap_on = 1'b1;
		// sender waits here until every result is back
		drain_results();
	endtask

	task automatic set_view(int phase);
		logic [63:0] sz, st;
		logic [31:0] bo, sl;
		logic [2:0]  dc;
		int d, r;
		drain_results();
		if (phase == 0) begin
			dc = 3'd4;
			sz = '1;
			st = {4{16'h8000}};
			bo = 32'h8000_0000;
			sl = '1;
		end else if (phase == 1) begin
			dc = 3'd4;
			sz = 64'h0003_0000_FFFF_0001;
			st = {4{16'h7FFF}};
			bo = 32'h7FFF_FFFF;
			sl = '0;
		end else begin
			dc = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) :
				3'($urandom_range(0, 7));
			for (d = 0; d < svag_pkg::PACK_DIMS; d++) begin
				r = $urandom_range(0, 19);
				sz[16*d +: 16] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
					(r == 2) ? 16'($urandom) : 16'($urandom_range(1, 6));
				r = $urandom_range(0, 19);
				st[16*d +: 16] = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF :
					(r == 2) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
			end
			r = $urandom_range(0, 9);
			bo = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
				(r == 2) ? $urandom : $urandom_range(0, 200);
			r = $urandom_range(0, 9);
			sl = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
				(r == 2) ? $urandom : $urandom_range(1, 400);
		end
		write_reg(svag_pkg::REG_DIM_COUNT, {61'b0, dc});
		write_reg(svag_pkg::REG_DIM_SIZES, sz);
		write_reg(svag_pkg::REG_DIM_STRIDES, st);
		write_reg(svag_pkg::REG_BASE_OFFSET, {32'b0, bo});
		write_reg(svag_pkg::REG_SOURCE_LENGTH, {32'b0, sl});
	endtask

	// mostly a flat index inside the view, now and then any 32-bit value
	function automatic logic [31:0] pick_flat();
		logic [63:0] total;
		int d;
		total = 64'd1;
		for (d = 0; d < dims_in_use(); d++)
			total = total * view_size(d);
		if (total == 0 || total > 64'hFFFF_FFFF || $urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(0, total[31:0] - 1);
	endfunction

	task automatic test_random_views();
		int phase, left, k;
		for (phase = 0; phase < 13; phase++) begin
			if (phase >= 11) begin
				stall_on = 1'b0;
				gap_on = 1'b0;
			end
			set_view(phase);
			left = 108;
			while (left > 0) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(1'($urandom_range(0, 1)), $urandom);
					left--;
				end else begin
					send_word(svag_pkg::CMD_START, pick_flat());
					left--;
					for (k = $urandom_range(0, 30); k > 0 && left > 0; k--) begin
						send_word(svag_pkg::CMD_ADVANCE, $urandom);
						left--;
					end
				end
			end
		end
	endtask

	task automatic finish_run();
		drain_results();
		repeat (200) @(posedge clk);
		$display("ran %0d starts and %0d advances across %0d register writes",
			n_starts, n_advances, n_writes);
		$display("%0d results came back clamped; %0d mismatches", n_clamped, n_errors);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	endtask

	initial begin
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		view_cfg = '0;
		view_cfg.dim_count = svag_pkg::DIM_COUNT_RST;
		view_cfg.source_length = svag_pkg::SOURCE_LENGTH_RST;
		for (int d = 0; d < svag_pkg::PACK_DIMS; d++)
			digit_q[d] = '0;
		run_off = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_advance();
		test_strided_walk();
		test_dim_count_limits();
		test_clamping();
		test_output_backpressure();
		test_random_views();
		finish_run();
	end

endmodule
